// ===== hdl/volume_brush_box_painter_top_defines.svh =====
// Assertion macros shared by the voxel brush painter RTL.
`ifndef VOLUME_BRUSH_BOX_PAINTER_TOP_DEFINES_SVH
`define VOLUME_BRUSH_BOX_PAINTER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while reset is held.
`define VBBP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while reset is held.
`define VBBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/vbbp_pkg.sv =====
// Shared types and constants of the voxel brush painter.
`default_nettype none

package vbbp_pkg;

    // Item operation codes
    localparam logic OP_PAINT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DMIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DMIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DMIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z = 3'd5;

    localparam logic [30:0] SCALE_RESET = 31'd4194304;

    // floor(v / 5) = (v * DIV5_RECIP) >> 34 for every 32-bit v
    localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;

    // Twelve grid index jobs: job = 4 * axis + kind
    localparam int NJOB  = 12;
    localparam int JOB_W = 4;
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam int KIND_PLUS_BIT  = 0;   // set: centre plus radius
    localparam int KIND_INNER_BIT = 1;   // set: inner radius

    typedef struct packed {
        logic               valid;
        logic signed [33:0] coord;
        logic signed [31:0] lo;
        logic        [30:0] scale;
    } t_grid_req;

endpackage

`default_nettype wire

// ===== hdl/vbbp_grid.sv =====
// Three-stage pipelined Q16.16 coordinate to clamped grid index unit.
`default_nettype none

module vbbp_grid
    import vbbp_pkg::*;
#(
    parameter int IW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_grid_req     i_req,
    input  wire logic [IW-1:0] i_limit,
    output logic               o_valid,
    output logic [IW-1:0]      o_idx
);

    logic signed [34:0] w_diff;
    logic [48:0]        w_t;
    logic [32:0]        w_idx;

    logic          r1_valid, r2_valid, r3_valid;
    logic          r1_pos, r2_pos;
    logic [16:0]   r1_hi;
    logic [15:0]   r1_lo;
    logic [30:0]   r1_scale;
    logic [IW-1:0] r1_limit, r2_limit;
    logic [47:0]   r2_phi;
    logic [46:0]   r2_plo;
    logic [IW-1:0] r3_idx;

    // offset from the domain bound; below 2^33 when positive
    assign w_diff = 35'(i_req.coord) - 35'(i_req.lo);

    assign w_t   = 49'(r2_phi) + 49'(r2_plo[46:16]);
    assign w_idx = w_t[48:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_req.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pos   <= !w_diff[34] && (w_diff != 35'sd0);
        r1_hi    <= w_diff[32:16];
        r1_lo    <= w_diff[15:0];
        r1_scale <= i_req.scale;
        r1_limit <= i_limit;

        r2_pos   <= r1_pos;
        r2_limit <= r1_limit;
        r2_phi   <= 48'(r1_hi) * 48'(r1_scale);
        r2_plo   <= 47'(r1_lo) * 47'(r1_scale);

        // nonpositive offset gives zero, past the grid saturates
        if (!r2_pos) begin
            r3_idx <= '0;
        end else if (w_idx > 33'(r2_limit)) begin
            r3_idx <= r2_limit;
        end else begin
            r3_idx <= w_idx[IW-1:0];
        end
    end

    assign o_valid = r3_valid;
    assign o_idx   = r3_idx;

endmodule

`default_nettype wire

// ===== hdl/volume_brush_box_painter_top.sv =====
// Top level of the two-channel voxel brush painter with its voxel memories.
`default_nettype none
`include "volume_brush_box_painter_top_defines.svh"

// Voxel brush painter. Holds an outer and an inner 32-bit channel per voxel
// of a SIZE_X x SIZE_Y x SIZE_Z grid in two synchronous memories, each with
// one write port and one registered read port.
// After reset the block sweeps both memories to zero, one voxel per cycle;
// busy stays high meanwhile, though configuration writes are taken at any
// time. An item is taken when start is high and busy low. A read passes
// through the READ and RTN states before its result strobe. A paint first
// works out twelve clamped grid bounds, after the divide by five for the
// inner radius, through one pipelined index unit and then writes one voxel
// per cycle over the outer box; the memory write port sets that rate. Each
// item gives one result, held on the output ports for exactly one cycle
// with o_result_valid high: the receiver cannot stall, so it must take the
// result in that cycle. Configuration is meant to change only while the
// block is idle.

module volume_brush_box_painter_top
    import vbbp_pkg::*;
#(
    parameter int SIZE_X = 64,
    parameter int SIZE_Y = 64,
    parameter int SIZE_Z = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // item channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_operation,
    input  wire logic signed [31:0]   i_pos_x,
    input  wire logic signed [31:0]   i_pos_y,
    input  wire logic signed [31:0]   i_pos_z,
    input  wire logic [30:0]          i_radius,
    input  wire logic [31:0]          i_value,
    input  wire logic [5:0]           i_read_x,
    input  wire logic [5:0]           i_read_y,
    input  wire logic [5:0]           i_read_z,
    // result channel
    output logic                      o_result_valid,
    output logic [31:0]               o_outer_value,
    output logic [31:0]               o_inner_value,
    output logic [31:0]               o_paint_total,
    // configuration channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    localparam int XW     = $clog2(SIZE_X);
    localparam int YW     = $clog2(SIZE_Y);
    localparam int ZW     = $clog2(SIZE_Z);
    localparam int IW_XY  = (XW > YW) ? XW : YW;
    localparam int IW     = (IW_XY > ZW) ? IW_XY : ZW;
    localparam int VOXELS = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int AW     = $clog2(VOXELS);

    localparam logic [AW-1:0] SX_A      = AW'(SIZE_X);
    localparam logic [AW-1:0] SY_A      = AW'(SIZE_Y);
    localparam logic [AW-1:0] LAST_VOX  = AW'(VOXELS - 1);
    localparam logic [IW-1:0] LIM_X     = IW'(SIZE_X - 1);
    localparam logic [IW-1:0] LIM_Y     = IW'(SIZE_Y - 1);
    localparam logic [IW-1:0] LIM_Z     = IW'(SIZE_Z - 1);
    localparam logic [JOB_W-1:0] JOB_END  = JOB_W'(NJOB);
    localparam logic [JOB_W-1:0] JOB_LAST = JOB_W'(NJOB - 1);

    // bound slots: outer min, outer max, inner min, inner max per axis
    localparam int SLOT_X = 0;
    localparam int SLOT_Y = 4;
    localparam int SLOT_Z = 8;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_IDX   = 3'd3;
    localparam logic [2:0] S_BOX   = 3'd4;
    localparam logic [2:0] S_PAINT = 3'd5;
    localparam logic [2:0] S_READ  = 3'd6;
    localparam logic [2:0] S_RTN   = 3'd7;

    function automatic logic [8:0] clamp_rd(input logic [5:0] v, input logic [8:0] lim);
        logic [8:0] wide;
        wide = {3'b000, v};
        return (wide > lim) ? lim : wide;
    endfunction

    function automatic logic [AW-1:0] vox_addr(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y,
                                               input logic [ZW-1:0] z);
        return (AW'(y) + AW'(z) * SY_A) * SX_A + AW'(x);
    endfunction

    // voxel memories
    logic [31:0] mem_outer [VOXELS];
    logic [31:0] mem_inner [VOXELS];

    // control registers
    logic [2:0]          r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [JOB_W-1:0]    r_issue, n_issue;
    logic [JOB_W-1:0]    r_collect, n_collect;
    logic                r_req_valid, n_req_valid;
    logic [31:0]         r_paint_count, n_paint_count;
    logic                r_res_valid, n_res_valid;
    logic signed [31:0]  r_dmin [3];
    logic signed [31:0]  n_dmin [3];
    logic [30:0]         r_scale [3];
    logic [30:0]         n_scale [3];

    // payload registers
    t_grid_req           r_req, n_req;
    logic [IW-1:0]       r_lim, n_lim;
    logic signed [31:0]  r_pos [3];
    logic signed [31:0]  n_pos [3];
    logic [30:0]         r_radius, n_radius;
    logic [31:0]         r_value, n_value;
    logic [29:0]         r_nr, n_nr;
    logic [IW-1:0]       r_bnd [NJOB];
    logic [IW-1:0]       n_bnd [NJOB];
    logic [XW-1:0]       r_cx, n_cx;
    logic [YW-1:0]       r_cy, n_cy;
    logic [ZW-1:0]       r_cz, n_cz;
    logic [AW-1:0]       r_raddr, n_raddr;
    logic [31:0]         r_rd_outer, r_rd_inner;
    logic [31:0]         r_out_outer, n_out_outer;
    logic [31:0]         r_out_inner, n_out_inner;
    logic [31:0]         r_out_total, n_out_total;

    // datapath wires
    logic [63:0]         w_nr_prod;
    logic [1:0]          w_axis;
    logic [30:0]         w_off;
    logic signed [31:0]  w_p;
    logic signed [31:0]  w_lo;
    logic [30:0]         w_s;
    logic [IW-1:0]       w_limit;
    logic signed [33:0]  w_p34, w_off34;
    logic                w_idx_valid;
    logic [IW-1:0]       w_idx;
    logic [XW-1:0]       w_vmin_x, w_vmax_x, w_nmin_x, w_nmax_x;
    logic [YW-1:0]       w_vmin_y, w_vmax_y, w_nmin_y, w_nmax_y;
    logic [ZW-1:0]       w_vmin_z, w_vmax_z, w_nmin_z, w_nmax_z;
    logic                w_in_inner, w_last_vox;
    logic [AW-1:0]       w_paint_addr, w_waddr;
    logic [31:0]         w_wdata;
    logic                w_we_outer, w_we_inner;

    // hold the full request struct in step with its valid bit
    t_grid_req           w_req_out;

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_res_valid;
    assign o_outer_value  = r_out_outer;
    assign o_inner_value  = r_out_inner;
    assign o_paint_total  = r_out_total;

    // inner radius: floor(2 * radius / 5) by reciprocal multiply
    assign w_nr_prod = 64'({r_radius, 1'b0}) * 64'(DIV5_RECIP);

    // select the axis and offset of the job being issued
    assign w_axis = r_issue[3:2];
    assign w_off  = r_issue[KIND_INNER_BIT] ? 31'(r_nr) : r_radius;

    always_comb begin
        case (w_axis)
            AXIS_X: begin
                w_p = r_pos[0]; w_lo = r_dmin[0]; w_s = r_scale[0]; w_limit = LIM_X;
            end
            AXIS_Y: begin
                w_p = r_pos[1]; w_lo = r_dmin[1]; w_s = r_scale[1]; w_limit = LIM_Y;
            end
            default: begin
                w_p = r_pos[2]; w_lo = r_dmin[2]; w_s = r_scale[2]; w_limit = LIM_Z;
            end
        endcase
    end

    assign w_p34   = 34'(w_p);
    assign w_off34 = signed'({3'b000, w_off});

    assign w_req_out = '{valid: r_req_valid, coord: r_req.coord,
                         lo: r_req.lo, scale: r_req.scale};

    vbbp_grid #(
        .IW (IW)
    ) u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req_out),
        .i_limit (r_lim),
        .o_valid (w_idx_valid),
        .o_idx   (w_idx)
    );

    // box bounds, narrowed to each axis
    assign w_vmin_x = r_bnd[SLOT_X + 0][XW-1:0];
    assign w_vmax_x = r_bnd[SLOT_X + 1][XW-1:0];
    assign w_nmin_x = r_bnd[SLOT_X + 2][XW-1:0];
    assign w_nmax_x = r_bnd[SLOT_X + 3][XW-1:0];
    assign w_vmin_y = r_bnd[SLOT_Y + 0][YW-1:0];
    assign w_vmax_y = r_bnd[SLOT_Y + 1][YW-1:0];
    assign w_nmin_y = r_bnd[SLOT_Y + 2][YW-1:0];
    assign w_nmax_y = r_bnd[SLOT_Y + 3][YW-1:0];
    assign w_vmin_z = r_bnd[SLOT_Z + 0][ZW-1:0];
    assign w_vmax_z = r_bnd[SLOT_Z + 1][ZW-1:0];
    assign w_nmin_z = r_bnd[SLOT_Z + 2][ZW-1:0];
    assign w_nmax_z = r_bnd[SLOT_Z + 3][ZW-1:0];

    assign w_in_inner = (r_cx >= w_nmin_x) && (r_cx <= w_nmax_x)
                     && (r_cy >= w_nmin_y) && (r_cy <= w_nmax_y)
                     && (r_cz >= w_nmin_z) && (r_cz <= w_nmax_z);
    assign w_last_vox = (r_cx == w_vmax_x) && (r_cy == w_vmax_y) && (r_cz == w_vmax_z);

    assign w_paint_addr = vox_addr(r_cx, r_cy, r_cz);

    // memory write port: clearing sweep or brush sweep
    assign w_we_outer = (r_state == S_CLEAR) || (r_state == S_PAINT);
    assign w_we_inner = (r_state == S_CLEAR) || ((r_state == S_PAINT) && w_in_inner);
    assign w_waddr    = (r_state == S_CLEAR) ? r_clr : w_paint_addr;
    assign w_wdata    = (r_state == S_CLEAR) ? 32'd0 : r_value;

    always_ff @(posedge i_clk) begin
        if (w_we_outer) begin
            mem_outer[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_inner) begin
            mem_inner[w_waddr] <= w_wdata;
        end
    end

    // registered read port, address held from the item transfer
    always_ff @(posedge i_clk) begin
        r_rd_outer <= mem_outer[r_raddr];
        r_rd_inner <= mem_inner[r_raddr];
    end

    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_issue       = r_issue;
        n_collect     = r_collect;
        n_req_valid   = 1'b0;
        n_paint_count = r_paint_count;
        n_res_valid   = 1'b0;
        n_dmin        = r_dmin;
        n_scale       = r_scale;
        n_req         = r_req;
        n_lim         = r_lim;
        n_pos         = r_pos;
        n_radius      = r_radius;
        n_value       = r_value;
        n_nr          = r_nr;
        n_bnd         = r_bnd;
        n_cx          = r_cx;
        n_cy          = r_cy;
        n_cz          = r_cz;
        n_raddr       = r_raddr;
        n_out_outer   = r_out_outer;
        n_out_inner   = r_out_inner;
        n_out_total   = r_out_total;

        // configuration transfer; unknown indexes drop
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DMIN_X:  n_dmin[0]  = i_cfg_data;
                CFG_DMIN_Y:  n_dmin[1]  = i_cfg_data;
                CFG_DMIN_Z:  n_dmin[2]  = i_cfg_data;
                CFG_SCALE_X: n_scale[0] = i_cfg_data[30:0];
                CFG_SCALE_Y: n_scale[1] = i_cfg_data[30:0];
                CFG_SCALE_Z: n_scale[2] = i_cfg_data[30:0];
                default: ;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == LAST_VOX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_pos[0] = i_pos_x;
                    n_pos[1] = i_pos_y;
                    n_pos[2] = i_pos_z;
                    n_radius = i_radius;
                    n_value  = i_value;
                    n_raddr  = vox_addr(XW'(clamp_rd(i_read_x, 9'(SIZE_X - 1))),
                                        YW'(clamp_rd(i_read_y, 9'(SIZE_Y - 1))),
                                        ZW'(clamp_rd(i_read_z, 9'(SIZE_Z - 1))));
                    n_state  = (i_operation == OP_READ) ? S_READ : S_DIV;
                end
            end
            S_DIV: begin
                n_nr      = w_nr_prod[63:34];
                n_issue   = '0;
                n_collect = '0;
                n_state   = S_IDX;
            end
            S_IDX: begin
                // issue one bound job a cycle into the index pipeline
                if (r_issue != JOB_END) begin
                    n_req_valid = 1'b1;
                    n_req.valid = 1'b1;
                    n_req.coord = r_issue[KIND_PLUS_BIT] ? (w_p34 + w_off34)
                                                         : (w_p34 - w_off34);
                    n_req.lo    = w_lo;
                    n_req.scale = w_s;
                    n_lim       = w_limit;
                    n_issue     = r_issue + 1'b1;
                end
                // collect results in issue order
                if (w_idx_valid) begin
                    n_bnd[r_collect] = w_idx;
                    n_collect        = r_collect + 1'b1;
                    if (r_collect == JOB_LAST) begin
                        n_state = S_BOX;
                    end
                end
            end
            S_BOX: begin
                n_cx    = w_vmin_x;
                n_cy    = w_vmin_y;
                n_cz    = w_vmin_z;
                n_state = S_PAINT;
            end
            S_PAINT: begin
                // advance x fastest, then y, then z
                if (r_cx != w_vmax_x) begin
                    n_cx = r_cx + 1'b1;
                end else begin
                    n_cx = w_vmin_x;
                    if (r_cy != w_vmax_y) begin
                        n_cy = r_cy + 1'b1;
                    end else begin
                        n_cy = w_vmin_y;
                        if (r_cz != w_vmax_z) begin
                            n_cz = r_cz + 1'b1;
                        end
                    end
                end
                if (w_last_vox) begin
                    n_paint_count = r_paint_count + 32'd1;
                    n_res_valid   = 1'b1;
                    n_out_outer   = 32'd0;
                    n_out_inner   = 32'd0;
                    n_out_total   = r_paint_count + 32'd1;
                    n_state       = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_RTN;
            end
            S_RTN: begin
                n_res_valid = 1'b1;
                n_out_outer = r_rd_outer;
                n_out_inner = r_rd_inner;
                n_out_total = r_paint_count;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_issue       <= '0;
            r_collect     <= '0;
            r_req_valid   <= 1'b0;
            r_paint_count <= 32'd0;
            r_res_valid   <= 1'b0;
            r_dmin[0]     <= 32'sd0;
            r_dmin[1]     <= 32'sd0;
            r_dmin[2]     <= 32'sd0;
            r_scale[0]    <= SCALE_RESET;
            r_scale[1]    <= SCALE_RESET;
            r_scale[2]    <= SCALE_RESET;
        end else begin
            r_state       <= n_state;
            r_clr         <= n_clr;
            r_issue       <= n_issue;
            r_collect     <= n_collect;
            r_req_valid   <= n_req_valid;
            r_paint_count <= n_paint_count;
            r_res_valid   <= n_res_valid;
            r_dmin        <= n_dmin;
            r_scale       <= n_scale;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_lim       <= n_lim;
        r_pos       <= n_pos;
        r_radius    <= n_radius;
        r_value     <= n_value;
        r_nr        <= n_nr;
        r_bnd       <= n_bnd;
        r_cx        <= n_cx;
        r_cy        <= n_cy;
        r_cz        <= n_cz;
        r_raddr     <= n_raddr;
        r_out_outer <= n_out_outer;
        r_out_inner <= n_out_inner;
        r_out_total <= n_out_total;
    end

    `VBBP_ASSERT_NEXT(a_paint_result, (r_state == S_PAINT) && w_last_vox, o_result_valid && (o_paint_total == r_paint_count) && (o_outer_value == 32'd0), "paint end without matching result")
    `VBBP_ASSERT_IMPLY(a_sweep_in_box, r_state == S_PAINT, (r_cx <= w_vmax_x) && (r_cy <= w_vmax_y) && (r_cz <= w_vmax_z), "brush sweep left the box")
    `VBBP_ASSERT_IMPLY(a_collect_order, r_state == S_IDX, r_collect <= r_issue, "more bounds collected than issued")
    `VBBP_ASSERT_NEXT(a_start_busy, start && !busy, busy, "item transfer did not raise busy")

endmodule

`default_nettype wire
